/* rtl/core/stoch_pkg.sv */
// ----------------------------------------------------------------------------
// Stochastic oscillator package
// Shared widths, constants and register indexes.
// ----------------------------------------------------------------------------
package stoch_pkg;

	localparam int K_MAX_DEF      = 64;
	localparam int D_MAX_DEF      = 16;
	localparam int PRICE_BITS_DEF = 32;

	localparam int IN_W   = 32;
	localparam int KV_W   = 15;
	localparam int KP_W   = 7;
	localparam int DP_W   = 5;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 1;

	localparam logic [KV_W-1:0] KD_FULL = 15'd25600;
	localparam logic [KV_W-1:0] KD_HALF = 15'd12800;

	localparam logic [IDX_W-1:0] REG_K_PERIOD = 1'b0;
	localparam logic [IDX_W-1:0] REG_D_PERIOD = 1'b1;

	// Step control handed from the top level down the cell row
	typedef struct packed {
		logic shift;   // a new bar enters cell 0, or the row rotates during the scan
		logic clear;   // restart: empty the fill marks
	} cell_ctl_t;

endpackage

/* rtl/core/stoch_cell.sv */
// ----------------------------------------------------------------------------
// Window cell
// Holds one bar (high, low) and a fill mark; passes its bar to the next cell.
// ----------------------------------------------------------------------------
module stoch_cell #(
	parameter int PRICE_BITS = stoch_pkg::PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stoch_pkg::cell_ctl_t  ctl,
	input  logic [PRICE_BITS-1:0] hi_in,
	input  logic [PRICE_BITS-1:0] lo_in,
	input  logic                  vld_in,
	output logic [PRICE_BITS-1:0] hi_out,
	output logic [PRICE_BITS-1:0] lo_out,
	output logic                  vld_out
);

	logic [PRICE_BITS-1:0] hi_q;
	logic [PRICE_BITS-1:0] lo_q;
	logic                  vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			hi_q <= hi_in;
			lo_q <= lo_in;
		end
	end

	assign hi_out  = hi_q;
	assign lo_out  = lo_q;
	assign vld_out = vld_q;

endmodule

/* rtl/core/stoch_div.sv */
// ----------------------------------------------------------------------------
// Scaled ratio divider
// floor(num*25600/den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stoch_div #(
	parameter int PRICE_BITS = stoch_pkg::PRICE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [PRICE_BITS-1:0]      num,
	input  logic [PRICE_BITS-1:0]      den,
	output logic                       done,
	output logic [stoch_pkg::KV_W-1:0] quo
);

	localparam int BW = 4;

	logic [PRICE_BITS-1:0]      num_q;
	logic [PRICE_BITS-1:0]      den_q;
	logic [PRICE_BITS-1:0]      rem_q;
	logic [stoch_pkg::KV_W-1:0] quo_q;
	logic [BW-1:0]              bit_q;
	logic                       busy_q;
	logic                       done_q;

	logic [PRICE_BITS-1:0]      r1;
	logic [PRICE_BITS-1:0]      r2;
	logic [stoch_pkg::KV_W-1:0] q1;
	logic [stoch_pkg::KV_W-1:0] q2;

	always_comb begin
		q1 = {quo_q[stoch_pkg::KV_W-2:0], 1'b0};
		if (rem_q >= den_q - rem_q) begin
			r1 = rem_q - (den_q - rem_q);
			q1 = q1 + 1'b1;
		end else begin
			r1 = rem_q + rem_q;
		end
		r2 = r1;
		q2 = q1;
		if (stoch_pkg::KD_FULL[bit_q]) begin
			if (r1 >= den_q - num_q) begin
				r2 = r1 - (den_q - num_q);
				q2 = q1 + 1'b1;
			end else begin
				r2 = r1 + num_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(stoch_pkg::KV_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= q2;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/core/stochastic_oscillator.sv */
// ----------------------------------------------------------------------------
// Stochastic oscillator %K / %D
// Row of window cells scanned one per cycle, then bit-serial dividers for %K and %D.
// ----------------------------------------------------------------------------
// %K needs no divide when the window is flat or the close is at or beyond the
// window extremes; the scan covers the whole cell row whatever k_period is.
// Throughput: one bar at a time; a bar is taken every cycle while the window
// fills, and while %D is still filling a bar gives no result and skips the %D
// divide. Scan = K_MAX-step rotation of the cell row, then a 15-step %K divide
// and a 15-step divide of the sum by d_period.
// Reset: asynchronous, active low; window and %K history are empty after it.
module stochastic_oscillator #(
	parameter int K_MAX      = stoch_pkg::K_MAX_DEF,
	parameter int D_MAX      = stoch_pkg::D_MAX_DEF,
	parameter int PRICE_BITS = stoch_pkg::PRICE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [95:0]                 s_tdata,  // high_price, low_price, close_price
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,  // k_value, d_value, pad
	input  logic                        cfg_we,
	input  logic [stoch_pkg::IDX_W-1:0] cfg_index,
	input  logic [stoch_pkg::CFG_W-1:0] cfg_data
);

	localparam int KW  = $clog2(K_MAX + 1);
	localparam int DW  = $clog2(D_MAX + 1);
	localparam int HW  = (D_MAX > 1) ? $clog2(D_MAX) : 1;
	localparam int SW  = stoch_pkg::KV_W + DW;
	localparam int KV  = stoch_pkg::KV_W;
	localparam int AW  = $clog2(KV + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_SUM, ST_AVG, ST_OUT} state_t;

	state_t                 state_q;
	logic [stoch_pkg::KP_W-1:0] kp_reg_q;
	logic [stoch_pkg::DP_W-1:0] dp_reg_q;
	logic [KW-1:0]          bars_q;
	logic [KW-1:0]          scan_q;
	logic [PRICE_BITS-1:0]  hh_q, ll_q, cl_q;
	logic [KV-1:0]          kv_q;
	logic [KV-1:0]          hist_q [D_MAX];
	logic [HW-1:0]          hpos_q;
	logic [DW-1:0]          kcnt_q;
	logic [SW-1:0]          ksum_q;
	logic [SW-1:0]          arem_q;
	logic [KV-1:0]          aquo_q;
	logic [AW-1:0]          abit_q;
	logic [31:0]            out_q;
	logic                   mv_q;

	logic [KW-1:0] kp_eff;
	logic [DW-1:0] dp_eff;

	always_comb begin
		if (kp_reg_q == '0) kp_eff = KW'(1);
		else if (32'(kp_reg_q) > K_MAX) kp_eff = KW'(K_MAX);
		else kp_eff = KW'(kp_reg_q);
		if (dp_reg_q == '0) dp_eff = DW'(1);
		else if (32'(dp_reg_q) > D_MAX) dp_eff = DW'(D_MAX);
		else dp_eff = DW'(dp_reg_q);
	end

	// cell row: cell 0 takes the new bar; during the scan the row rotates
	stoch_pkg::cell_ctl_t ctl;
	logic [PRICE_BITS-1:0] hi_w [K_MAX+1];
	logic [PRICE_BITS-1:0] lo_w [K_MAX+1];
	logic                  v_w  [K_MAX+1];
	logic                  accept;
	logic                  scan_rot;
	logic                  scan_end;
	logic                  scan_use;
	logic                  out_load;

	assign scan_rot  = (state_q == ST_SCAN);
	assign scan_end  = (scan_q == KW'(K_MAX));
	// last cell shows bar K_MAX-1-scan_q; the window is the newest kp_eff bars
	assign scan_use  = scan_rot && !scan_end && (32'(scan_q) + 32'(kp_eff) >= K_MAX);
	assign out_load  = (state_q == ST_OUT) && (!mv_q || m_tready);

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign ctl.shift = accept || (scan_rot && !scan_end);
	assign ctl.clear = cfg_we;
	assign hi_w[0]   = scan_rot ? hi_w[K_MAX] : s_tdata[PRICE_BITS-1:0];
	assign lo_w[0]   = scan_rot ? lo_w[K_MAX] : s_tdata[32 +: PRICE_BITS];
	assign v_w[0]    = scan_rot ? v_w[K_MAX] : 1'b1;

	for (genvar g = 0; g < K_MAX; g++) begin : g_cell
		stoch_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.hi_in(hi_w[g]), .lo_in(lo_w[g]), .vld_in(v_w[g]),
			.hi_out(hi_w[g+1]), .lo_out(lo_w[g+1]), .vld_out(v_w[g+1])
		);
	end

	logic                  div_start, div_done;
	logic [PRICE_BITS-1:0] div_num, div_den;
	logic [KV-1:0]         div_quo;

	stoch_div #(.PRICE_BITS(PRICE_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	logic          k_special;
	logic [KV-1:0] k_fixed;
	always_comb begin
		k_special = 1'b1;
		k_fixed   = stoch_pkg::KD_HALF;
		div_num   = cl_q - ll_q;
		div_den   = hh_q - ll_q;
		if (hh_q == ll_q) begin
			k_fixed = stoch_pkg::KD_HALF;
		end else if (hh_q > ll_q) begin
			if (cl_q <= ll_q) k_fixed = '0;
			else if (cl_q >= hh_q) k_fixed = stoch_pkg::KD_FULL;
			else k_special = 1'b0;
		end else begin
			div_num = ll_q - cl_q;
			div_den = ll_q - hh_q;
			if (cl_q >= ll_q) k_fixed = '0;
			else if (cl_q <= hh_q) k_fixed = stoch_pkg::KD_FULL;
			else k_special = 1'b0;
		end
	end
	assign div_start = scan_rot && scan_end && !k_special;

	logic [HW-1:0] old_idx;
	assign old_idx = HW'((32'(hpos_q) + D_MAX - 32'(dp_eff)) % D_MAX);

	// first %D step starts from the sum bits above the quotient
	logic [SW-1:0] arem_cur;
	logic [SW-1:0] arem_sh;
	logic [SW-1:0] dp_w;
	logic [AW-1:0] a_idx;
	assign arem_cur = (abit_q == '0) ? (ksum_q >> KV) : arem_q;
	assign a_idx    = AW'(KV - 1) - abit_q;
	assign arem_sh  = {arem_cur[SW-2:0], ksum_q[a_idx]};
	assign dp_w     = SW'(dp_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kp_reg_q <= 7'd14;
			dp_reg_q <= 5'd3;
			bars_q   <= '0;
			kcnt_q   <= '0;
			ksum_q   <= '0;
			hpos_q   <= '0;
			mv_q     <= 1'b0;
			scan_q   <= '0;
			abit_q   <= '0;
		end else begin
			if (out_load) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					stoch_pkg::REG_K_PERIOD: kp_reg_q <= cfg_data;
					stoch_pkg::REG_D_PERIOD: dp_reg_q <= cfg_data[stoch_pkg::DP_W-1:0];
					default: ;
				endcase
				bars_q <= '0;
				kcnt_q <= '0;
				ksum_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (32'(bars_q) < K_MAX) bars_q <= bars_q + 1'b1;
						if (bars_q + 1'b1 >= kp_eff || 32'(bars_q) >= K_MAX) begin
							state_q <= ST_SCAN;
							scan_q  <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= k_special ? ST_SUM : ST_DIV;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (kcnt_q >= dp_eff) begin
						ksum_q <= ksum_q - SW'(hist_q[old_idx]) + SW'(kv_q);
					end else begin
						kcnt_q <= kcnt_q + 1'b1;
						ksum_q <= ksum_q + SW'(kv_q);
					end
					hpos_q <= HW'((32'(hpos_q) + 1) % D_MAX);
					if (kcnt_q >= dp_eff || kcnt_q + 1'b1 >= dp_eff) begin
						state_q <= ST_AVG;
						abit_q  <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_AVG: begin
					if (32'(abit_q) == KV - 1) state_q <= ST_OUT;
					abit_q <= abit_q + 1'b1;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cl_q <= s_tdata[64 +: PRICE_BITS];
			hh_q <= '0;
			ll_q <= '1;
		end
		if (scan_use) begin
			if (hi_w[K_MAX] > hh_q) hh_q <= hi_w[K_MAX];
			if (lo_w[K_MAX] < ll_q) ll_q <= lo_w[K_MAX];
		end
		if (scan_rot && scan_end) kv_q <= k_fixed;
		if (div_done) kv_q <= div_quo;
		if (state_q == ST_SUM) begin
			hist_q[hpos_q] <= kv_q;
			aquo_q <= '0;
		end
		// restoring divide of k_sum by d_period, one quotient bit a cycle
		if (state_q == ST_AVG) begin
			if (arem_sh >= dp_w) begin
				arem_q <= arem_sh - dp_w;
				aquo_q <= {aquo_q[KV-2:0], 1'b1};
			end else begin
				arem_q <= arem_sh;
				aquo_q <= {aquo_q[KV-2:0], 1'b0};
			end
		end
		if (out_load) out_q <= {2'b00, aquo_q, kv_q};
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;

endmodule

/* rtl/core/stoch_checker.sv */
// ----------------------------------------------------------------------------
// Stochastic oscillator port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module stoch_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");

	a_kmax: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:0] <= 15'd25600) else $error("k out of range");

	a_dmax: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:15] <= 15'd25600) else $error("d out of range");

	// a result never shows up the cycle right after a bar is taken
	a_nofast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid) else $error("result too early");

endmodule

bind stochastic_oscillator stoch_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
